// ===== rtl/core/wvenv_pkg.sv =====
// Shared types and constants of the wavetable voice.
`default_nettype none

package wvenv_pkg;

  localparam int DefSampleDepth = 65536;

  localparam logic [2:0] REG_DAH   = 3'd0;
  localparam logic [2:0] REG_DR    = 3'd1;
  localparam logic [2:0] REG_SUS   = 3'd2;
  localparam logic [2:0] REG_PITCH = 3'd3;
  localparam logic [2:0] REG_GAIN  = 3'd4;
  localparam logic [2:0] REG_LOOP  = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;
  localparam logic [2:0] REG_FB    = 3'd7;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_RENDER  = 2'd3;

  localparam logic [2:0] PH_INIT    = 3'd0;
  localparam logic [2:0] PH_DELAY   = 3'd1;
  localparam logic [2:0] PH_ATTACK  = 3'd2;
  localparam logic [2:0] PH_HOLD    = 3'd3;
  localparam logic [2:0] PH_DECAY   = 3'd4;
  localparam logic [2:0] PH_SUSTAIN = 3'd5;
  localparam logic [2:0] PH_RELEASE = 3'd6;
  localparam logic [2:0] PH_FINAL   = 3'd7;

  localparam logic [1:0] LOOP_FOREVER = 2'd1;
  localparam logic [1:0] LOOP_HELD    = 2'd2;

  localparam logic [15:0] FULL_SCALE = 16'h8000;
  localparam logic [15:0] SUS_FLOOR  = 16'd32;

  localparam logic signed [49:0] MixBias  = 50'sd524288000;
  localparam logic signed [26:0] SatSpan  = 27'sd4096000;
  localparam logic [23:0]        MixRecip = 24'd8589935;

  typedef logic signed [15:0] smp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ENV, ST_EMUL, ST_EDIV, ST_MST, ST_MIX, ST_UPD
  } vstate_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic        filt_en;
    logic [15:0] fb;
  } mix_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/wvenv_smem.sv =====
// Synchronous sample memory with one write port and one registered read port.
`default_nettype none

module wvenv_smem #(
  parameter int DEPTH = wvenv_pkg::DefSampleDepth
) (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [$clog2(DEPTH)-1:0]         waddr,
  input  wire  wvenv_pkg::smp_t            wdata,
  input  wire                              re,
  input  wire  [$clog2(DEPTH)-1:0]         raddr,
  output wvenv_pkg::smp_t                  rdata
);
  import wvenv_pkg::*;

  smp_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wvenv_div.sv =====
// Restoring divider that yields a 16-bit quotient, one bit per cycle.
`default_nettype none

module wvenv_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  wvenv_pkg::div_req_t req,
  output logic                   done,
  output logic [15:0]            quot
);
  import wvenv_pkg::*;

  localparam int QW = 16;
  localparam int CW = $clog2(QW);

  logic [31:0]           rem_r;
  logic [QW-1:0]         lo_r;
  logic [QW-1:0]         q_r;
  logic [31:0]           d_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [32:0]           trial;
  logic [32:0]           diff;
  logic                  ge;

  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CW'(QW - 1));
      if (req.start) begin
        rem_r  <= req.dividend[47:16];
        lo_r   <= req.dividend[15:0];
        d_r    <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[31:0] : trial[31:0];
        lo_r  <= {lo_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/wvenv_mix.sv =====
// One channel of gain, envelope, scaling, saturation and an optional one-pole low-pass.
`default_nettype none

module wvenv_mix (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  wvenv_pkg::mix_ctl_t ctl,
  input  wire  wvenv_pkg::smp_t   sample,
  input  wire  [15:0]             gain,
  input  wire  [15:0]             env,
  input  wire  wvenv_pkg::smp_t   fmem,
  output logic                    done,
  output wvenv_pkg::smp_t         y
);
  import wvenv_pkg::*;

  logic [6:0]         v_r;
  logic signed [32:0] sg_r;
  logic signed [49:0] m_r;
  logic signed [49:0] tb;
  logic signed [26:0] t;
  logic signed [26:0] u_full;
  logic [22:0]        u_r;
  logic               hi_r, lo_r, hi2_r, lo2_r;
  logic [46:0]        p_r;
  logic [16:0]        q;
  smp_t               x_r, x2_r, y_r;
  logic [15:0]        b;
  logic [16:0]        a;
  logic signed [33:0] pa_r, pb_r;
  logic signed [34:0] fsum;
  logic signed [19:0] fr;
  smp_t               fsat;

  assign tb     = m_r + MixBias;
  assign t      = tb[49:23];
  assign u_full = t + SatSpan;
  assign q      = p_r[46:30];
  assign b      = (ctl.fb > FULL_SCALE) ? FULL_SCALE : ctl.fb;
  assign a      = 17'h10000 - {1'b0, b} - 17'h8000;
  assign fsum   = 35'(pa_r) + 35'(pb_r) + 35'sd16384;
  assign fr     = fsum[34:15];

  always_comb begin
    if (fr > 20'sd32767) begin
      fsat = 16'sh7fff;
    end else if (fr < -20'sd32768) begin
      fsat = 16'sh8000;
    end else begin
      fsat = fr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], ctl.start};
    end
  end

  always_ff @(posedge clk) begin
    sg_r  <= sample * $signed({1'b0, gain});
    m_r   <= sg_r * $signed({1'b0, env});
    hi_r  <= t >= SatSpan;
    lo_r  <= t < -SatSpan;
    u_r   <= u_full[22:0];
    p_r   <= {24'b0, u_r} * {23'b0, MixRecip};
    hi2_r <= hi_r;
    lo2_r <= lo_r;
    if (hi2_r) begin
      x_r <= 16'sh7fff;
    end else if (lo2_r) begin
      x_r <= 16'sh8000;
    end else begin
      x_r <= {~q[15], q[14:0]};
    end
    pa_r <= $signed({1'b0, a}) * x_r;
    pb_r <= $signed({2'b0, b}) * fmem;
    x2_r <= x_r;
    y_r  <= ctl.filt_en ? fsat : x2_r;
  end

  assign done = v_r[6];
  assign y    = y_r;

endmodule

`default_nettype wire

// ===== rtl/core/wavetable_voice_envelope_core.sv =====
// Top level of the sampled-instrument voice with its DAHDSR envelope.
// Write, start and release transfers complete when accepted and leave the block ready.
// A render transfer reads the sample memory, walks the envelope phases at one phase per
// cycle, runs the envelope divider for attack, decay and release levels, and passes the
// seven stage mix pipeline. A render of a silent voice skips these steps and goes
// straight to the output update. A finished frame waits in the output register while
// the next transfer is taken, and the block stalls only when a second frame is done
// before the first has been taken.
`default_nettype none

module wavetable_voice_envelope_core #(
  parameter int SAMPLE_DEPTH = wvenv_pkg::DefSampleDepth
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [1:0]            in_action,
  input  wire  [15:0]           in_sample_addr,
  input  wire  wvenv_pkg::smp_t in_sample_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output wvenv_pkg::smp_t       out_left_out,
  output wvenv_pkg::smp_t       out_right_out,
  output logic                  out_voice_active,
  input  wire                   cfg_we,
  input  wire  [2:0]            cfg_index,
  input  wire  [47:0]           cfg_wdata
);
  import wvenv_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);

  vstate_t     state_r, state_nxt;
  logic [47:0] cfg_dah_r;
  logic [31:0] cfg_dr_r;
  logic [15:0] cfg_sus_r;
  logic [23:0] cfg_pitch_r;
  logic [31:0] cfg_gain_r;
  logic [47:0] cfg_loop_r;
  logic [2:0]  cfg_mode_r;
  logic [15:0] cfg_fb_r;

  logic        playing_r, gate_r, zero_r, rd_ok_r, out_valid_r, out_act_r;
  logic [2:0]  ph_r;
  logic [31:0] el_r, pos_r;
  logic [15:0] rsl_r, env_r, mult_r;
  smp_t        fm_l_r, fm_r_r, res_l_r, res_r_r, out_l_r, out_rr_r;

  logic        acc, mem_we, mem_re, el_ge, div_done, mix_done_l, mix_done_r;
  logic        loops, wrap, slot_free;
  logic [15:0] sus_c, div_q, div_lvl, lend;
  logic [31:0] cur_dur, el_sat, pos_sat, pos_jump, wr_ext, rd_ext;
  logic [32:0] el_sum, pos_sum;
  smp_t        rdata, s_val, mix_l, mix_r;
  div_req_t    div_req;
  mix_ctl_t    mix_ctl;

  assign acc       = in_valid && in_ready;
  assign sus_c     = (cfg_sus_r > FULL_SCALE) ? FULL_SCALE : cfg_sus_r;
  assign wr_ext    = {16'b0, in_sample_addr};
  assign rd_ext    = {16'b0, pos_r[31:16]};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    case (ph_r)
      PH_DELAY:   cur_dur = {cfg_dah_r[15:0], 16'b0};
      PH_ATTACK:  cur_dur = {cfg_dah_r[31:16], 16'b0};
      PH_HOLD:    cur_dur = {cfg_dah_r[47:32], 16'b0};
      PH_DECAY:   cur_dur = {cfg_dr_r[15:0], 16'b0};
      PH_RELEASE: cur_dur = {cfg_dr_r[31:16], 16'b0};
      default:    cur_dur = '0;
    endcase
  end
  assign el_ge = el_r >= cur_dur;

  always_comb begin
    case (ph_r)
      PH_ATTACK: div_lvl = div_q;
      PH_DECAY:  div_lvl = FULL_SCALE - div_q;
      default:   div_lvl = rsl_r - div_q;
    endcase
  end

  assign loops    = (cfg_mode_r[1:0] == LOOP_FOREVER) ||
                    ((cfg_mode_r[1:0] == LOOP_HELD) && gate_r);
  assign lend     = loops ? cfg_loop_r[31:16] : cfg_loop_r[47:32];
  assign el_sum   = {1'b0, el_r} + {9'b0, cfg_pitch_r};
  assign pos_sum  = {1'b0, pos_r} + {9'b0, cfg_pitch_r};
  assign el_sat   = el_sum[32] ? 32'hffff_ffff : el_sum[31:0];
  assign pos_sat  = pos_sum[32] ? 32'hffff_ffff : pos_sum[31:0];
  assign wrap     = pos_sat >= {lend, 16'b0};
  assign pos_jump = pos_sat + {cfg_loop_r[15:0], 16'b0} - {lend, 16'b0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (in_action == ACT_RENDER)) begin
          state_nxt = playing_r ? ST_READ : ST_UPD;
        end
      end
      ST_READ: state_nxt = ST_ENV;
      ST_ENV: begin
        case (ph_r)
          PH_INIT: state_nxt = ST_ENV;
          PH_DELAY, PH_HOLD: state_nxt = el_ge ? ST_ENV : ST_MST;
          PH_ATTACK, PH_DECAY: state_nxt = el_ge ? ST_ENV : ST_EMUL;
          PH_SUSTAIN: begin
            if (sus_c <= SUS_FLOOR) begin
              state_nxt = ST_UPD;
            end else if (gate_r) begin
              state_nxt = ST_MST;
            end
          end
          PH_RELEASE: state_nxt = el_ge ? ST_UPD : ST_EMUL;
          default: state_nxt = ST_UPD;
        endcase
      end
      ST_EMUL: state_nxt = ST_EDIV;
      ST_EDIV: if (div_done) state_nxt = ST_MST;
      ST_MST: state_nxt = ST_MIX;
      ST_MIX: if (mix_done_l) state_nxt = ST_UPD;
      ST_UPD: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    mem_re           = acc && (in_action == ACT_RENDER);
    mem_we           = acc && (in_action == ACT_WRITE) && (wr_ext < 32'(SAMPLE_DEPTH));
    div_req.start    = (state_r == ST_EMUL);
    div_req.dividend = {32'b0, mult_r} * {16'b0, el_r};
    div_req.divisor  = cur_dur;
    mix_ctl.start    = (state_r == ST_MST);
    mix_ctl.filt_en  = cfg_mode_r[2];
    mix_ctl.fb       = cfg_fb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dah_r   <= '0;
      cfg_dr_r    <= '0;
      cfg_sus_r   <= FULL_SCALE;
      cfg_pitch_r <= 24'h010000;
      cfg_gain_r  <= '0;
      cfg_loop_r  <= '0;
      cfg_mode_r  <= '0;
      cfg_fb_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DAH:   cfg_dah_r   <= cfg_wdata;
        REG_DR:    cfg_dr_r    <= cfg_wdata[31:0];
        REG_SUS:   cfg_sus_r   <= cfg_wdata[15:0];
        REG_PITCH: cfg_pitch_r <= cfg_wdata[23:0];
        REG_GAIN:  cfg_gain_r  <= cfg_wdata[31:0];
        REG_LOOP:  cfg_loop_r  <= cfg_wdata;
        REG_MODE:  cfg_mode_r  <= cfg_wdata[2:0];
        REG_FB:    cfg_fb_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      playing_r   <= 1'b0;
      gate_r      <= 1'b0;
      ph_r        <= PH_INIT;
      el_r        <= '0;
      pos_r       <= '0;
      rsl_r       <= '0;
      fm_l_r      <= '0;
      fm_r_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && !((state_r == ST_UPD) && slot_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            case (in_action)
              ACT_START: begin
                gate_r    <= 1'b1;
                playing_r <= 1'b1;
                pos_r     <= '0;
                ph_r      <= PH_INIT;
                el_r      <= '0;
                rsl_r     <= '0;
              end
              ACT_RELEASE: gate_r <= 1'b0;
              ACT_RENDER: begin
                zero_r  <= !playing_r;
                rd_ok_r <= rd_ext < 32'(SAMPLE_DEPTH);
              end
              default: ;
            endcase
          end
        end
        ST_ENV: begin
          case (ph_r)
            PH_INIT: begin
              ph_r <= PH_DELAY;
              el_r <= '0;
            end
            PH_DELAY, PH_ATTACK, PH_HOLD, PH_DECAY: begin
              if (el_ge) begin
                el_r <= el_r - cur_dur;
                ph_r <= ph_r + 3'd1;
              end else if (ph_r == PH_DELAY) begin
                env_r <= '0;
              end else if (ph_r == PH_HOLD) begin
                env_r <= FULL_SCALE;
                if (!gate_r) begin
                  rsl_r <= FULL_SCALE;
                  ph_r  <= PH_RELEASE;
                  el_r  <= '0;
                end
              end else if (ph_r == PH_ATTACK) begin
                mult_r <= FULL_SCALE;
              end else begin
                mult_r <= FULL_SCALE - sus_c;
              end
            end
            PH_SUSTAIN: begin
              if (sus_c <= SUS_FLOOR) begin
                ph_r   <= PH_FINAL;
                zero_r <= 1'b1;
              end else if (gate_r) begin
                env_r <= sus_c;
              end else begin
                rsl_r <= sus_c;
                ph_r  <= PH_RELEASE;
                el_r  <= '0;
              end
            end
            PH_RELEASE: begin
              if (el_ge) begin
                ph_r   <= PH_FINAL;
                zero_r <= 1'b1;
              end else begin
                mult_r <= rsl_r;
              end
            end
            default: begin
              ph_r   <= PH_FINAL;
              zero_r <= 1'b1;
            end
          endcase
        end
        ST_EDIV: begin
          if (div_done) begin
            env_r <= div_lvl;
            if (((ph_r == PH_ATTACK) || (ph_r == PH_DECAY)) && !gate_r) begin
              rsl_r <= div_lvl;
              ph_r  <= PH_RELEASE;
              el_r  <= '0;
            end
          end
        end
        ST_MIX: begin
          if (mix_done_l) begin
            res_l_r <= mix_l;
            res_r_r <= mix_r;
            if (cfg_mode_r[2]) begin
              fm_l_r <= mix_l;
              fm_r_r <= mix_r;
            end
          end
        end
        ST_UPD: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (zero_r) begin
              playing_r <= 1'b0;
              out_l_r   <= '0;
              out_rr_r  <= '0;
              out_act_r <= 1'b0;
            end else begin
              el_r     <= el_sat;
              out_l_r  <= res_l_r;
              out_rr_r <= res_r_r;
              if (wrap && !loops) begin
                pos_r     <= pos_sat;
                playing_r <= 1'b0;
                out_act_r <= 1'b0;
              end else begin
                pos_r     <= wrap ? pos_jump : pos_sat;
                out_act_r <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign s_val = rd_ok_r ? rdata : '0;

  wvenv_smem #(
    .DEPTH (SAMPLE_DEPTH)
  ) u_smem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ext[AW-1:0]),
    .wdata (in_sample_word),
    .re    (mem_re),
    .raddr (rd_ext[AW-1:0]),
    .rdata (rdata)
  );

  wvenv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  wvenv_mix u_mix_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mix_ctl),
    .sample (s_val),
    .gain   (cfg_gain_r[15:0]),
    .env    (env_r),
    .fmem   (fm_l_r),
    .done   (mix_done_l),
    .y      (mix_l)
  );

  wvenv_mix u_mix_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mix_ctl),
    .sample (s_val),
    .gain   (cfg_gain_r[31:16]),
    .env    (env_r),
    .fmem   (fm_r_r),
    .done   (mix_done_r),
    .y      (mix_r)
  );

  assign out_valid        = out_valid_r;
  assign out_left_out     = out_l_r;
  assign out_right_out    = out_rr_r;
  assign out_voice_active = out_act_r;

`ifndef SYNTHESIS
  // The envelope level handed to the mix never exceeds full scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MST) |-> (env_r <= FULL_SCALE))
    else $error("envelope level above full scale");

  // A division is only started for a phase of nonzero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != 32'd0))
    else $error("envelope division by zero");

  // Both mix lanes finish together and only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mix_done_l || mix_done_r) |-> (mix_done_l && mix_done_r && (state_r == ST_MIX)))
    else $error("mix result outside the mix wait");

  // A level is mixed only from a live envelope phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MST) |-> ((ph_r != PH_INIT) && (ph_r != PH_FINAL)))
    else $error("mix started from a dead envelope phase");
`endif

endmodule

`default_nettype wire

// ===== bench/wavetable_voice_envelope_core_tb.sv =====
// Self-checking testbench of the wavetable voice with its DAHDSR envelope.
`default_nettype none

module wavetable_voice_envelope_core_tb;
  import wvenv_pkg::*;

  localparam int Depth = 65536;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] addr;
    logic [15:0] word;
  } voice_cmd_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        active;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [15:0] in_sample_addr = '0;
  smp_t in_sample_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  smp_t out_left_out, out_right_out;
  logic out_voice_active;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  wavetable_voice_envelope_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_sample_addr(in_sample_addr), .in_sample_word(in_sample_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_left_out(out_left_out),
    .out_right_out(out_right_out), .out_voice_active(out_voice_active),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state.
  logic signed [15:0] mem [Depth];
  logic [47:0] r_dah, r_loop;
  logic [31:0] r_dr, r_gain;
  logic [15:0] r_sus, r_fb;
  logic [23:0] r_pitch;
  logic [2:0] r_mode;
  logic playing, gate;
  logic [2:0] phase;
  logic [31:0] elapsed, position;
  logic [31:0] rel_level;
  longint fm_l, fm_r;

  voice_cmd_t pending[$];
  frame_t frames_due[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet = 0;

  function automatic longint round_div(longint n, longint d);
    longint a, b, q;
    a = 2 * n + d;
    b = 2 * d;
    q = a / b;
    if (a % b != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic go_release(logic [31:0] lvl);
    rel_level = lvl;
    phase = PH_RELEASE;
    elapsed = 0;
  endtask

  task automatic env_eval(input logic [31:0] sus, output logic [31:0] lvl);
    longint unsigned dly, att, hld, dec, rel;
    bit done;
    dly = longint'(r_dah[15:0]) << 16;
    att = longint'(r_dah[31:16]) << 16;
    hld = longint'(r_dah[47:32]) << 16;
    dec = longint'(r_dr[15:0]) << 16;
    rel = longint'(r_dr[31:16]) << 16;
    done = 0;
    lvl = 0;
    if (phase == PH_INIT) begin
      phase = PH_DELAY;
      elapsed = 0;
    end
    while (!done) begin
      case (phase)
        PH_DELAY: begin
          if (elapsed >= dly) begin
            elapsed = elapsed - 32'(dly);
            phase = PH_ATTACK;
          end else begin
            lvl = 0;
            done = 1;
          end
        end
        PH_ATTACK: begin
          if (elapsed >= att) begin
            elapsed = elapsed - 32'(att);
            phase = PH_HOLD;
          end else begin
            lvl = 32'((longint'(elapsed) * 32768) / att);
            if (!gate) go_release(lvl);
            done = 1;
          end
        end
        PH_HOLD: begin
          if (elapsed >= hld) begin
            elapsed = elapsed - 32'(hld);
            phase = PH_DECAY;
          end else begin
            lvl = 32768;
            if (!gate) go_release(lvl);
            done = 1;
          end
        end
        PH_DECAY: begin
          if (elapsed >= dec) begin
            elapsed = elapsed - 32'(dec);
            phase = PH_SUSTAIN;
          end else begin
            lvl = 32768 - 32'((longint'(32768 - sus) * longint'(elapsed)) / dec);
            if (!gate) go_release(lvl);
            done = 1;
          end
        end
        PH_SUSTAIN: begin
          if (sus <= SUS_FLOOR) begin
            phase = PH_FINAL;
            lvl = 0;
            done = 1;
          end else if (gate) begin
            lvl = sus;
            done = 1;
          end else begin
            go_release(sus);
          end
        end
        PH_RELEASE: begin
          if (elapsed >= rel) begin
            phase = PH_FINAL;
            lvl = 0;
          end else begin
            lvl = rel_level - 32'((longint'(rel_level) * longint'(elapsed)) / rel);
          end
          done = 1;
        end
        default: begin
          phase = PH_FINAL;
          lvl = 0;
          done = 1;
        end
      endcase
    end
  endtask

  task automatic predict_voice(voice_cmd_t c);
    logic loops;
    logic [31:0] sus, env, lstart, lend;
    longint s, l, r, b, a;
    frame_t f;
    case (c.action)
      ACT_WRITE: mem[c.addr] = c.word;
      ACT_START: begin
        gate = 1;
        playing = 1;
        position = 0;
        phase = PH_INIT;
        elapsed = 0;
        rel_level = 0;
      end
      ACT_RELEASE: gate = 0;
      default: begin
        l = 0;
        r = 0;
        if (playing) begin
          loops = (r_mode[1:0] == LOOP_FOREVER) || (r_mode[1:0] == LOOP_HELD && gate);
          sus = (r_sus > 16'h8000) ? 32768 : 32'(r_sus);
          s = longint'(mem[position[31:16]]);
          env_eval(sus, env);
          if (phase == PH_FINAL) begin
            playing = 0;
          end else begin
            lstart = 32'(r_loop[15:0]);
            lend = loops ? 32'(r_loop[31:16]) : 32'(r_loop[47:32]);
            l = clip16(round_div(s * 128 * longint'(r_gain[15:0]) * longint'(env),
                                 longint'(125) << 30));
            r = clip16(round_div(s * 128 * longint'(r_gain[31:16]) * longint'(env),
                                 longint'(125) << 30));
            if (r_mode[2]) begin
              b = (r_fb > 16'h8000) ? 32768 : longint'(r_fb);
              a = 32768 - b;
              l = clip16(round_div(a * l + b * fm_l, 32768));
              r = clip16(round_div(a * r + b * fm_r, 32768));
              fm_l = l;
              fm_r = r;
            end
            elapsed = add_sat(elapsed, 32'(r_pitch));
            position = add_sat(position, 32'(r_pitch));
            if (position >= (lend << 16)) begin
              if (loops) position = position + (lstart << 16) - (lend << 16);
              else playing = 0;
            end
          end
        end
        f.left = l[15:0];
        f.right = r[15:0];
        f.active = playing;
        frames_due.push_back(f);
      end
    endcase
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_voice('{in_action, in_sample_addr, in_sample_word});
      end
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          {in_action, in_sample_addr, in_sample_word} <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    frame_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame L=%0d R=%0d act=%0b", $time,
                   out_left_out, out_right_out, out_voice_active);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (out_left_out !== want.left) begin
            $display("%0t: left expected %0d got %0d", $time,
                     $signed(want.left), out_left_out);
            errors++;
          end
          if (out_right_out !== want.right) begin
            $display("%0t: right expected %0d got %0d", $time,
                     $signed(want.right), out_right_out);
            errors++;
          end
          if (out_voice_active !== want.active) begin
            $display("%0t: active expected %0b got %0b", $time,
                     want.active, out_voice_active);
            errors++;
          end
        end
      end
      if (quiet >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DAH: r_dah = val;
      REG_DR: r_dr = val[31:0];
      REG_SUS: r_sus = val[15:0];
      REG_PITCH: r_pitch = val[23:0];
      REG_GAIN: r_gain = val[31:0];
      REG_LOOP: r_loop = val;
      REG_MODE: r_mode = val[2:0];
      default: r_fb = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || frames_due.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic put(logic [1:0] act, logic [15:0] addr, logic [15:0] word);
    pending.push_back('{act, addr, word});
  endtask

  // Keeps all reads inside the written table of 256 words.
  task automatic random_settings(bit extreme);
    logic [15:0] ls, le, se;
    logic [2:0] md;
    logic [23:0] pit;
    md = 3'($urandom_range(0, 7));
    le = 16'($urandom_range(1, 255));
    ls = 16'($urandom_range(0, le - 1));
    se = 16'($urandom_range(1, 255));
    pit = extreme ? 24'hFF_FFFF : 24'($urandom_range(4096, 200000));
    if ((md[1:0] == LOOP_FOREVER || md[1:0] == LOOP_HELD) &&
        (pit > {8'(le - ls), 16'h0})) begin
      pit = {8'(le - ls), 16'h0};
    end
    set_reg(REG_DAH, extreme ? {16'($urandom_range(0, 3)), 16'hFFFF, 16'd0}
                             : {16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 6))});
    set_reg(REG_DR, {16'($urandom_range(0, 12)), 16'($urandom_range(0, 8))});
    case ($urandom_range(3))
      0: set_reg(REG_SUS, 48'($urandom_range(0, 32)));
      1: set_reg(REG_SUS, 48'($urandom_range(32769, 65535)));
      default: set_reg(REG_SUS, 48'($urandom_range(33, 32768)));
    endcase
    set_reg(REG_PITCH, {24'd0, pit});
    set_reg(REG_GAIN, {16'd0, 16'($urandom), 16'($urandom)});
    set_reg(REG_LOOP, {se, le, ls});
    set_reg(REG_MODE, {45'd0, md});
    set_reg(REG_FB, extreme ? 48'hFFFF : 48'($urandom_range(0, 40000)));
  endtask

  task automatic note_run(int frames);
    put(ACT_START, 16'($urandom), 16'($urandom));
    for (int i = 0; i < frames; i++) begin
      if ($urandom_range(99) < 6) put(ACT_RELEASE, 16'($urandom), 16'($urandom));
      else if ($urandom_range(99) < 4) put(ACT_WRITE, 16'($urandom_range(0, 255)),
                                          16'($urandom));
      else put(ACT_RENDER, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    playing = 0; gate = 0; phase = PH_INIT; elapsed = 0; position = 0;
    rel_level = 0; fm_l = 0; fm_r = 0;
    r_dah = 0; r_dr = 0; r_sus = 16'h8000; r_pitch = 24'h010000;
    r_gain = 0; r_loop = 0; r_mode = 0; r_fb = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the table first, with extreme words and top address bits.
    for (int i = 0; i < 256; i++) put(ACT_WRITE, 16'(i), 16'($urandom));
    put(ACT_WRITE, 16'd0, 16'h7FFF);
    put(ACT_WRITE, 16'd1, 16'h8000);
    put(ACT_WRITE, 16'hFFFF, 16'hFFFF);
    put(ACT_RENDER, 16'd0, 16'd0);
    put(ACT_RELEASE, 16'd0, 16'd0);
    drain();

    // Directed: full gains, zero then short phases, no write actions.
    set_reg(REG_GAIN, 48'hFFFF_FFFF);
    set_reg(REG_LOOP, {16'd4, 16'd3, 16'd1});
    set_reg(REG_MODE, 48'd1);
    put(ACT_START, 0, 0);
    repeat (4) put(ACT_RENDER, 0, 0);
    put(ACT_RELEASE, 0, 0);
    repeat (3) put(ACT_RENDER, 0, 0);
    drain();
    set_reg(REG_DAH, {16'd1, 16'd2, 16'd1});
    set_reg(REG_DR, {16'd2, 16'd2});
    set_reg(REG_SUS, 48'd16);
    set_reg(REG_MODE, 48'd6);
    set_reg(REG_FB, 48'd32768);
    put(ACT_START, 0, 0);
    repeat (8) put(ACT_RENDER, 0, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 58; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 58; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      random_settings(p == 5 || p == 11);
      if (p == 7) set_reg(REG_DAH, 48'hFFFF_FFFF_FFFF);
      repeat (2) note_run($urandom_range(8, 22));
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
